// ===== sv/rsa_pkg.sv =====
// Shared types and constants for the record slot allocator.
package rsa_pkg;

  localparam int DISK_W   = 27;
  localparam int BLOCK_W  = 17;
  localparam int RECORD_W = 13;
  localparam int CFG_W    = 27;
  localparam int CFG_IDX_W = 2;

  localparam logic [DISK_W-1:0]   DISK_RST   = 27'd67108864;
  localparam logic [BLOCK_W-1:0]  BLOCK_RST  = 17'd512;
  localparam logic [RECORD_W-1:0] RECORD_RST = 13'd32;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISK   = 2'd0,
    REG_BLOCK  = 2'd1,
    REG_RECORD = 2'd2
  } reg_idx_t;

endpackage

// ===== sv/record_slot_allocator_core.sv =====
// Record slot allocator: LIFO free stack in front of a per-block bump allocator.
// A request is decided in stage 1 and its result registered in stage 2 (out_valid).
// Throughput: one request per cycle while not busy; results cannot be stalled.
// A config write raises busy (registered, recalc_r) while the block base is rebuilt
// with a single multiply (current block times block size).
// Reset (sync, rst_n low) clears state, sets config defaults; stack RAM not cleared.
module record_slot_allocator_core #(
  parameter int FREE_DEPTH  = 256,
  parameter int OFFSET_BITS = 26
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request beat
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_cmd,
  input  logic [OFFSET_BITS-1:0]             in_free_offset,
  // result beat
  output logic                               out_valid,
  output logic [OFFSET_BITS-1:0]             out_slot_offset,
  output logic [1:0]                         out_status,
  output logic                               out_reused,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsa_pkg::CFG_W-1:0]          cfg_data
);

  // address / count widths for the stack
  localparam int AW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int CW = $clog2(FREE_DEPTH + 1);
  // product width: block index times block size, plus headroom for two adds
  localparam int PW = OFFSET_BITS + rsa_pkg::BLOCK_W + 2;
  localparam logic [PW-1:0] DISK_CAP = PW'(1) << OFFSET_BITS;
  localparam logic [CW-1:0] DEPTH_C  = CW'(FREE_DEPTH);

  // config registers
  logic [rsa_pkg::DISK_W-1:0]   disk_r;
  logic [rsa_pkg::BLOCK_W-1:0]  blk_r;
  logic [rsa_pkg::RECORD_W-1:0] rec_r;
  logic                         cfg_wr;

  // allocator state; base_r tracks cur_blk_r * blk_r
  logic [OFFSET_BITS-1:0]      cur_blk_r, cur_blk_nxt;
  logic [PW-1:0]               base_r, base_nxt;
  logic [rsa_pkg::BLOCK_W-1:0] fill_r, fill_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        recalc_r;

  // free stack RAM
  logic [OFFSET_BITS-1:0] stack_mem [FREE_DEPTH];
  logic [OFFSET_BITS-1:0] rd_data_r;
  logic [CW-1:0]          cnt_m1;
  logic [AW-1:0]          pop_addr;
  logic                   push;

  // stage 1 (decision) and stage 2 (result) registers
  logic                   s1_valid_r, s1_pop_r, s1_pop_nxt;
  rsa_pkg::status_t       s1_status_r, s1_status_nxt;
  logic [OFFSET_BITS-1:0] s1_ofs_r, s1_ofs_nxt;
  logic                   out_valid_r;
  logic [OFFSET_BITS-1:0] out_ofs_r;
  rsa_pkg::status_t       out_status_r;
  logic                   out_reused_r;

  // fit-test terms
  logic                        accept;
  logic [PW-1:0]               disk_eff, end1, end2, here_sum;
  logic [rsa_pkg::BLOCK_W:0]   fill_sum;
  logic                        zero_size, fits, can_open;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = recalc_r;
  assign accept    = start && !busy;

  assign disk_eff  = (PW'(disk_r) > DISK_CAP) ? DISK_CAP : PW'(disk_r);
  assign end1      = base_r + PW'(blk_r);
  assign end2      = end1 + PW'(blk_r);
  assign here_sum  = base_r + PW'(fill_r);
  assign fill_sum  = {1'b0, fill_r} + (rsa_pkg::BLOCK_W + 1)'(rec_r);
  assign zero_size = (blk_r == '0) || (rec_r == '0);
  assign fits      = (fill_sum <= {1'b0, blk_r}) && (end1 <= disk_eff);
  assign can_open  = ((rsa_pkg::BLOCK_W)'(rec_r) <= blk_r) && (end2 <= disk_eff);

  assign cnt_m1    = cnt_r - CW'(1);
  assign pop_addr  = cnt_m1[AW-1:0];

  // request decision
  always_comb begin
    cur_blk_nxt   = cur_blk_r;
    base_nxt      = base_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    push          = 1'b0;
    s1_pop_nxt    = 1'b0;
    s1_status_nxt = rsa_pkg::ST_OK;
    s1_ofs_nxt    = '0;
    if (recalc_r) begin
      // rebuild base after a size change
      base_nxt = PW'(cur_blk_r) * PW'(blk_r);
    end else if (accept) begin
      if (in_cmd == rsa_pkg::CMD_FREE) begin
        if (cnt_r == DEPTH_C) begin
          s1_status_nxt = rsa_pkg::ST_OVF;
        end else begin
          push    = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end else if (cnt_r != '0) begin
        s1_pop_nxt = 1'b1;
        cnt_nxt    = cnt_m1;
      end else if (zero_size) begin
        s1_status_nxt = rsa_pkg::ST_FULL;
      end else if (fits) begin
        s1_ofs_nxt = here_sum[OFFSET_BITS-1:0];
        fill_nxt   = fill_sum[rsa_pkg::BLOCK_W-1:0];
      end else if (can_open) begin
        cur_blk_nxt = cur_blk_r + OFFSET_BITS'(1);
        base_nxt    = end1;
        s1_ofs_nxt  = end1[OFFSET_BITS-1:0];
        fill_nxt    = (rsa_pkg::BLOCK_W)'(rec_r);
      end else begin
        s1_status_nxt = rsa_pkg::ST_FULL;
      end
    end
  end

  // config registers and allocator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_r    <= rsa_pkg::DISK_RST;
      blk_r     <= rsa_pkg::BLOCK_RST;
      rec_r     <= rsa_pkg::RECORD_RST;
      cur_blk_r <= '0;
      base_r    <= '0;
      fill_r    <= '0;
      cnt_r     <= '0;
      recalc_r  <= 1'b0;
    end else begin
      cur_blk_r <= cur_blk_nxt;
      base_r    <= base_nxt;
      fill_r    <= fill_nxt;
      cnt_r     <= cnt_nxt;
      recalc_r  <= cfg_wr;
      if (cfg_wr) begin
        case (cfg_index)
          rsa_pkg::REG_DISK:   disk_r <= cfg_data[rsa_pkg::DISK_W-1:0];
          rsa_pkg::REG_BLOCK:  blk_r  <= cfg_data[rsa_pkg::BLOCK_W-1:0];
          rsa_pkg::REG_RECORD: rec_r  <= cfg_data[rsa_pkg::RECORD_W-1:0];
          default: ;  // unknown index: ignored
        endcase
      end
    end
  end

  // stack RAM: one write, one registered read of the top entry
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[cnt_r[AW-1:0]] <= in_free_offset;
    end
    rd_data_r <= stack_mem[pop_addr];
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_pop_r     <= s1_pop_nxt;
    s1_status_r  <= s1_status_nxt;
    s1_ofs_r     <= s1_ofs_nxt;
    out_ofs_r    <= s1_pop_r ? rd_data_r : s1_ofs_r;
    out_status_r <= s1_status_r;
    out_reused_r <= s1_pop_r;
  end

  assign out_valid       = out_valid_r;
  assign out_slot_offset = out_ofs_r;
  assign out_status      = out_status_r;
  assign out_reused      = out_reused_r;

`ifndef SYNTHESIS
  a_out_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result beat without a request two cycles earlier");

  a_reuse_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reused) |-> (out_status == rsa_pkg::ST_OK))
    else $error("reused slot reported with error status");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("free stack count above depth");

  a_cfg_blocks_start: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> busy)
    else $error("request window open during base rebuild");
`endif

endmodule

// ===== tb/tb_record_slot_allocator_core.sv =====
// Self-checking bench for the record slot allocator: predicts every result beat and compares it.
module tb_record_slot_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FREE_DEPTH  = 256;
  localparam int OFS_W       = 26;
  localparam int DISK_W      = rsa_pkg::DISK_W;
  localparam int BLOCK_W     = rsa_pkg::BLOCK_W;
  localparam int RECORD_W    = rsa_pkg::RECORD_W;
  localparam int CFG_W       = rsa_pkg::CFG_W;
  localparam int CFG_IDX_W   = rsa_pkg::CFG_IDX_W;
  localparam int RESULT_LAT  = 2;     // accept edge to the edge that takes the result
  localparam int QUIET_LIMIT = 1000;  // cycles with no beat of any kind

  // one result beat as the allocator should produce it
  typedef struct packed {
    logic [OFS_W-1:0] slot;
    logic [1:0]       status;
    logic             reused;
  } slot_reply_t;

  // Predictor plus expectation queue. Holds its own copy of the registers,
  // the bump pointer (block index, fill) and the LIFO free stack.
  class slot_scoreboard;
    logic [DISK_W-1:0]   disk_sz   = rsa_pkg::DISK_RST;
    logic [BLOCK_W-1:0]  blk_sz    = rsa_pkg::BLOCK_RST;
    logic [RECORD_W-1:0] rec_sz    = rsa_pkg::RECORD_RST;
    longint unsigned     cur_block = 0;
    longint unsigned     fill      = 0;
    logic [OFS_W-1:0]    stack_mem [FREE_DEPTH];
    int                  stack_top = 0;
    int                  stack_peak = 0;
    slot_reply_t         reply_q [$];
    logic [OFS_W-1:0]    granted [$];   // recent grants, fed back as realistic frees
    int errors = 0;
    int n_req = 0, n_free = 0, n_ovf = 0, n_bump = 0, n_reuse = 0, n_full = 0, n_cfg = 0;

    function int pending();
      return reply_q.size();
    endfunction

    function void note_config(rsa_pkg::reg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        rsa_pkg::REG_DISK:   disk_sz = val[DISK_W-1:0];
        rsa_pkg::REG_BLOCK:  blk_sz  = val[BLOCK_W-1:0];
        rsa_pkg::REG_RECORD: rec_sz  = val[RECORD_W-1:0];
        default: ;
      endcase
      n_cfg++;
    endfunction

    function void note_request(rsa_pkg::cmd_t cmd, logic [OFS_W-1:0] ofs);
      longint unsigned disk;
      slot_reply_t     r;
      bit              granted_ok;
      disk = disk_sz;
      if (disk > (64'd1 << OFS_W)) disk = 64'd1 << OFS_W;  // offsets cap the usable disk
      r.slot   = '0;
      r.status = rsa_pkg::ST_OK;
      r.reused = 1'b0;
      n_req++;
      if (cmd == rsa_pkg::CMD_FREE) begin
        n_free++;
        if (stack_top >= FREE_DEPTH) begin
          r.status = rsa_pkg::ST_OVF;   // push dropped
          n_ovf++;
        end else begin
          stack_mem[stack_top] = ofs;
          stack_top++;
          if (stack_top > stack_peak) stack_peak = stack_top;
        end
      end else if (stack_top > 0) begin
        stack_top--;
        r.slot   = stack_mem[stack_top];
        r.reused = 1'b1;
        n_reuse++;
        granted.insert(granted.size(), r.slot);
      end else if (blk_sz == 0 || rec_sz == 0) begin
        r.status = rsa_pkg::ST_FULL;
        n_full++;
      end else begin
        granted_ok = 1'b1;
        if (!(fill + rec_sz <= blk_sz && (cur_block + 1) * blk_sz <= disk)) begin
          // current block can't take it: open the next one if there is room
          if (rec_sz > blk_sz || (cur_block + 2) * blk_sz > disk) begin
            granted_ok = 1'b0;
          end else begin
            cur_block++;
            fill = 0;
          end
        end
        if (granted_ok) begin
          r.slot = OFS_W'(cur_block * blk_sz + fill);
          fill += rec_sz;
          n_bump++;
          granted.insert(granted.size(), r.slot);
        end else begin
          r.status = rsa_pkg::ST_FULL;
          n_full++;
        end
      end
      if (granted.size() > 64) void'(granted.pop_front());
      reply_q.insert(reply_q.size(), r);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [OFS_W-1:0] slot, logic [1:0] st, logic reused);
      slot_reply_t want;
      if (reply_q.size() == 0) begin
        report_mismatch("unexpected result beat", 64'({st, slot}), '0);
        return;
      end
      want = reply_q.pop_front();
      if (slot !== want.slot)     report_mismatch("slot_offset", 64'(slot), 64'(want.slot));
      if (st !== want.status)     report_mismatch("status", 64'(st), 64'(want.status));
      if (reused !== want.reused) report_mismatch("reused", 64'(reused), 64'(want.reused));
    endtask
  endclass

  // ---------------------------------------------------------------------
  // DUT inputs start at known values; everything after time 0 is driven
  // with nonblocking assignments at the rising edge.
  // ---------------------------------------------------------------------
  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic                in_cmd         = 1'b0;
  logic [OFS_W-1:0]    in_free_offset = '0;
  logic                cfg_valid      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_W-1:0]    cfg_data       = '0;
  logic                busy;
  logic                out_valid;
  logic [OFS_W-1:0]    out_slot_offset;
  logic [1:0]          out_status;
  logic                out_reused;
  logic                cfg_ready;

  slot_scoreboard sb = new();

  record_slot_allocator_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_free_offset  (in_free_offset),
    .out_valid       (out_valid),
    .out_slot_offset (out_slot_offset),
    .out_status      (out_status),
    .out_reused      (out_reused),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Result beats last one cycle and can't be stalled: sample every edge.
  // Values read here are the pre-edge ones, so no race with the DUT flops.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_slot_offset, out_status, out_reused);
  end

  // Watchdog: any input beat, result beat or register write keeps it quiet.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1 ||
          (cfg_valid && cfg_ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: %0d cycles without any beat", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // One request beat. start stays high from one beat to the next when the
  // sender doesn't idle, so it is only ever assigned once per time step.
  // hold_off: drop start and wait until every outstanding result has come.
  task automatic send_request(input rsa_pkg::cmd_t cmd, input logic [OFS_W-1:0] ofs,
                              input int idle_pct, input bit hold_off);
    if (hold_off) begin
      start <= 1'b0;
      @(posedge clk);
      while (sb.pending() != 0) @(posedge clk);
    end
    while ($urandom_range(0, 99) < idle_pct) begin
      start          <= 1'b0;
      in_cmd         <= 1'($urandom_range(0, 1));   // junk while start is low
      in_free_offset <= OFS_W'($urandom);
      @(posedge clk);
    end
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_free_offset <= ofs;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(cmd, ofs);
  endtask

  // Stop sending, let all results land, then idle for slack set from RESULT_LAT.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (RESULT_LAT + 2) @(posedge clk);
  endtask

  // Write all three registers back to back; valid stays up between beats.
  task automatic apply_settings(input logic [DISK_W-1:0] disk,
                                input logic [BLOCK_W-1:0] blk,
                                input logic [RECORD_W-1:0] rec);
    rsa_pkg::reg_idx_t idx;
    logic [CFG_W-1:0]  val;
    for (int i = 0; i < 3; i++) begin
      idx = rsa_pkg::reg_idx_t'(i);
      case (idx)
        rsa_pkg::REG_DISK:  val = CFG_W'(disk);
        rsa_pkg::REG_BLOCK: val = CFG_W'(blk);
        default:            val = CFG_W'(rec);
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (cfg_ready !== 1'b1);
      sb.note_config(idx, val);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random phase: new geometry, the disk mostly sized two to eight blocks past the ones
  // already used, so the disk fills inside the phase; then a mix of allocs and frees.
  // n_flood leading frees push the stack into overflow.
  task automatic run_random_phase(input int n_flood, input int n_items, input int free_pct,
                                  input int idle_pct);
    logic [BLOCK_W-1:0]  blk;
    logic [RECORD_W-1:0] rec;
    longint unsigned     disk;
    int                  rec_cap;
    rsa_pkg::cmd_t       cmd;
    logic [OFS_W-1:0]    ofs;
    drain();
    if ($urandom_range(0, 9) == 0) blk = BLOCK_W'($urandom);
    else blk = BLOCK_W'($urandom_range(1, 64));
    rec_cap = (blk == 0) ? 1 : ((blk > 8191) ? 8191 : int'(blk));
    if ($urandom_range(0, 3) == 0) rec = RECORD_W'($urandom);
    else rec = RECORD_W'($urandom_range(1, rec_cap));
    case ($urandom_range(0, 5))
      0:       disk = 64'h7FF_FFFF;
      1:       disk = 64'h400_0000 + $urandom_range(0, 32'h3FF_FFFF);  // above offset range
      default: disk = (sb.cur_block + $urandom_range(2, 8)) * blk + $urandom_range(0, blk);
    endcase
    if (disk > 64'h7FF_FFFF) disk = 64'h7FF_FFFF;
    apply_settings(DISK_W'(disk), blk, rec);
    for (int i = 0; i < n_flood + n_items; i++) begin
      ofs = OFS_W'($urandom);   // allocs carry junk offsets too
      if (i < n_flood || $urandom_range(0, 99) < free_pct) begin
        cmd = rsa_pkg::CMD_FREE;
        case ($urandom_range(0, 9))
          0: ofs = '0;
          1: ofs = '1;
          2, 3, 4, 5: begin
            // give back the latest grant
            if (sb.granted.size() != 0) begin
              ofs = sb.granted[sb.granted.size() - 1];
              sb.granted.delete(sb.granted.size() - 1);
            end
          end
          default: ;
        endcase
      end else begin
        cmd = rsa_pkg::CMD_ALLOC;
      end
      send_request(cmd, ofs, idle_pct, $urandom_range(0, 99) < 3);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: reset geometry, bump, free extremes, LIFO reuse ---
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);
    send_request(rsa_pkg::CMD_ALLOC, '1, 0, 0);
    send_request(rsa_pkg::CMD_FREE,  '0, 0, 0);
    send_request(rsa_pkg::CMD_FREE,  '1, 0, 0);
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);   // gets the all-ones offset back
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);   // then zero
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);   // stack empty again, bump

    // next block would run past a 100 byte disk: full; reuse still works
    drain();
    apply_settings(DISK_W'(100), BLOCK_W'(64), RECORD_W'(32));
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);
    send_request(rsa_pkg::CMD_FREE,  26'h2AA_AAAA, 0, 0);
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);

    // disk smaller than one block, then record larger than a block
    drain();
    apply_settings(DISK_W'(10), BLOCK_W'(64), RECORD_W'(8));
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);
    drain();
    apply_settings(DISK_W'(4096), BLOCK_W'(16), RECORD_W'(100));
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);

    // zero record size: bump always full, stack reuse unaffected
    drain();
    apply_settings('1, '1, '0);
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);
    send_request(rsa_pkg::CMD_FREE,  26'h155_5555, 0, 0);
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);

    // zero block size
    drain();
    apply_settings('1, '0, '1);
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);

    // block of 65536 and record of 4096 on a disk above the offset range
    drain();
    apply_settings('1, BLOCK_W'(65536), RECORD_W'(4096));
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);

    // empty disk
    drain();
    apply_settings('0, BLOCK_W'(1), RECORD_W'(1));
    send_request(rsa_pkg::CMD_ALLOC, '0, 0, 0);

    // --- random: sender idles 36%, then 53%, then not at all ---
    run_random_phase(0,   90, 20, 36);
    run_random_phase(0,   90, 50, 36);
    run_random_phase(262, 30, 30, 53);   // flood the stack past its depth
    run_random_phase(0,   80, 20, 0);
    run_random_phase(0,   80, 50, 0);

    drain();
    $display("Covered %0d request beats: %0d frees (%0d overflowed), %0d bump grants,",
             sb.n_req, sb.n_free, sb.n_ovf, sb.n_bump);
    $display("%0d reuses, %0d disk full; %0d register writes over %0d geometries, stack peak %0d",
             sb.n_reuse, sb.n_full, sb.n_cfg, sb.n_cfg / 3, sb.stack_peak);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
